// ===== rtl/cpv_pkg.sv =====
package cpv_pkg;

    localparam int SQRT_STEPS = 25;
    localparam int CORDIC_STAGES = 16;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef struct packed {
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] rim_x;
        logic signed [15:0] rim_y;
        logic [9:0] vertex_index;
    } in_beat_t;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
    } out_beat_t;

    typedef struct packed {
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [33:0] dist2;
        logic [31:0] phase;
    } job_t;

    function automatic logic [31:0] atan_turns(input int i);
        logic [31:0] t;
        unique case (i)
            0: t = 32'h20000000;
            1: t = 32'h12E4051E;
            2: t = 32'h09FB385B;
            3: t = 32'h051111D4;
            4: t = 32'h028B0D43;
            5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E;
            7: t = 32'h00517C55;
            8: t = 32'h0028BE53;
            9: t = 32'h00145F2F;
            10: t = 32'h000A2F98;
            11: t = 32'h000517CC;
            12: t = 32'h00028BE6;
            13: t = 32'h000145F3;
            14: t = 32'h0000A2F9;
            default: t = 32'h0000517C;
        endcase
        return t;
    endfunction

    function automatic logic signed [15:0] round_q15(input logic signed [33:0] v);
        logic [33:0] mag;
        logic [33:0] r;
        logic signed [34:0] s;
        mag = v[33] ? 34'(-v) : v;
        r = (mag + 34'd16384) >> 15;
        s = v[33] ? -$signed({1'b0, r}) : $signed({1'b0, r});
        if (s > 35'sd32767) return 16'sh7fff;
        if (s < -35'sd32768) return 16'sh8000;
        return s[15:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [43:0] v);
        if (v > 44'sd32767) return 16'sh7fff;
        if (v < -44'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

endpackage

// ===== rtl/cpv_front.sv =====
module cpv_front #(
    parameter int MAX_LOG2 = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [3:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  cpv_pkg::in_beat_t  in_beat,
    output logic               job_valid,
    input  logic               job_ready,
    output cpv_pkg::job_t      job
);

    logic [3:0] res_log2_reg;
    logic       valid_reg;
    cpv_pkg::job_t job_reg;
    cpv_pkg::job_t job_next;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [33:0] dx_sq;
    logic signed [33:0] dy_sq;
    logic [4:0] l_eff;
    logic [31:0] k;

    always_comb begin
        dx = 17'(in_beat.center_x) - 17'(in_beat.rim_x);
        dy = 17'(in_beat.center_y) - 17'(in_beat.rim_y);
        dx_sq = 34'(dx) * 34'(dx);
        dy_sq = 34'(dy) * 34'(dy);
        l_eff = {1'b0, res_log2_reg};
        if (l_eff < 5'd1) l_eff = 5'd1;
        if (l_eff > 5'(MAX_LOG2)) l_eff = 5'(MAX_LOG2);
        k = 32'(in_beat.vertex_index) & ((32'd1 << l_eff) - 32'd1);
        job_next.center_x = in_beat.center_x;
        job_next.center_y = in_beat.center_y;
        job_next.dist2 = $unsigned(dx_sq) + $unsigned(dy_sq);
        job_next.phase = k << (6'd32 - 6'(l_eff));
    end

    assign in_ready = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_log2_reg <= 4'd6;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) res_log2_reg <= cfg_wr_data;
            if (in_ready) valid_reg <= in_valid;
        end
        if (in_ready && in_valid) job_reg <= job_next;
    end

endmodule

// ===== rtl/cpv_back.sv =====
module cpv_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               job_valid,
    output logic               job_ready,
    input  cpv_pkg::job_t      job,
    output logic               out_valid,
    input  logic               out_ready,
    output cpv_pkg::out_beat_t out_beat
);

    localparam int NS = cpv_pkg::SQRT_STEPS;
    localparam int NC = cpv_pkg::CORDIC_STAGES;
    localparam int DEPTH = NS + 4;

    logic [DEPTH-1:0] v_reg;
    logic adv;

    logic [49:0] rem_reg [NS+1];
    logic [49:0] res_reg [NS+1];
    logic signed [33:0] x_reg [NS+1];
    logic signed [33:0] y_reg [NS+1];
    logic signed [32:0] z_reg [NS+1];
    logic [1:0] q_reg [NS+1];
    logic signed [15:0] cx_reg [NS+1];
    logic signed [15:0] cy_reg [NS+1];

    logic signed [15:0] c15_reg;
    logic signed [15:0] s15_reg;
    logic [24:0] r8_reg;
    logic signed [15:0] cx2_reg;
    logic signed [15:0] cy2_reg;
    logic signed [41:0] px_reg;
    logic signed [41:0] py_reg;
    logic signed [15:0] cx3_reg;
    logic signed [15:0] cy3_reg;
    cpv_pkg::out_beat_t out_reg;

    assign adv = !v_reg[DEPTH-1] || out_ready;
    assign job_ready = adv;
    assign out_valid = v_reg[DEPTH-1];
    assign out_beat = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= '0;
        else if (adv) v_reg <= {v_reg[DEPTH-2:0], job_valid};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= {job.dist2, 16'd0};
            res_reg[0] <= '0;
            x_reg[0] <= cpv_pkg::CORDIC_GAIN_Q30;
            y_reg[0] <= '0;
            z_reg[0] <= $signed({3'b000, job.phase[29:0]});
            q_reg[0] <= job.phase[31:30];
            cx_reg[0] <= job.center_x;
            cy_reg[0] <= job.center_y;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_st
        logic [49:0] bitv;
        logic [49:0] trial;
        logic [49:0] rem_n;
        logic [49:0] res_n;
        logic signed [33:0] x_n;
        logic signed [33:0] y_n;
        logic signed [32:0] z_n;
        always_comb begin
            bitv = 50'd1 << (2 * (NS - 1 - i));
            trial = res_reg[i] + bitv;
            if (rem_reg[i] >= trial) begin
                rem_n = rem_reg[i] - trial;
                res_n = (res_reg[i] >> 1) + bitv;
            end else begin
                rem_n = rem_reg[i];
                res_n = res_reg[i] >> 1;
            end
            x_n = x_reg[i];
            y_n = y_reg[i];
            z_n = z_reg[i];
            if (i < NC) begin
                if (z_reg[i] >= 0) begin
                    x_n = x_reg[i] - (y_reg[i] >>> i);
                    y_n = y_reg[i] + (x_reg[i] >>> i);
                    z_n = z_reg[i] - $signed({1'b0, cpv_pkg::atan_turns(i)});
                end else begin
                    x_n = x_reg[i] + (y_reg[i] >>> i);
                    y_n = y_reg[i] - (x_reg[i] >>> i);
                    z_n = z_reg[i] + $signed({1'b0, cpv_pkg::atan_turns(i)});
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[i+1] <= rem_n;
                res_reg[i+1] <= res_n;
                x_reg[i+1] <= x_n;
                y_reg[i+1] <= y_n;
                z_reg[i+1] <= z_n;
                q_reg[i+1] <= q_reg[i];
                cx_reg[i+1] <= cx_reg[i];
                cy_reg[i+1] <= cy_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            unique case (q_reg[NS])
                2'd0: begin
                    c15_reg <= cpv_pkg::round_q15(x_reg[NS]);
                    s15_reg <= cpv_pkg::round_q15(y_reg[NS]);
                end
                2'd1: begin
                    c15_reg <= cpv_pkg::round_q15(-y_reg[NS]);
                    s15_reg <= cpv_pkg::round_q15(x_reg[NS]);
                end
                2'd2: begin
                    c15_reg <= cpv_pkg::round_q15(-x_reg[NS]);
                    s15_reg <= cpv_pkg::round_q15(-y_reg[NS]);
                end
                default: begin
                    c15_reg <= cpv_pkg::round_q15(y_reg[NS]);
                    s15_reg <= cpv_pkg::round_q15(-x_reg[NS]);
                end
            endcase
            r8_reg <= res_reg[NS][24:0];
            cx2_reg <= cx_reg[NS];
            cy2_reg <= cy_reg[NS];
            px_reg <= $signed({1'b0, r8_reg}) * c15_reg;
            py_reg <= $signed({1'b0, r8_reg}) * s15_reg;
            cx3_reg <= cx2_reg;
            cy3_reg <= cy2_reg;
            out_reg.vertex_x <= place(cx3_reg, px_reg);
            out_reg.vertex_y <= place(cy3_reg, py_reg);
        end
    end

    function automatic logic signed [15:0] place(input logic signed [15:0] c,
                                                 input logic signed [41:0] p);
        logic signed [43:0] v;
        logic signed [43:0] q;
        v = (44'(c) <<< 23) + 44'(p);
        q = (v + (v[43] ? 44'sd8388607 : 44'sd0)) >>> 23;
        return cpv_pkg::sat16(q);
    endfunction

    ast_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_beat))
        else $error("result changed under stall");
    ast_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(v_reg))
        else $error("pipeline moved while stalled");
    ast_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid |-> job_ready)
        else $error("back end stalled with empty output");

endmodule

// ===== rtl/circle_polygon_vertex_unit.sv =====
// Circle polygon vertex unit.
// The s_ channel takes one beat per vertex request: centre, rim point and
// vertex index. The m_ channel returns one beat with the vertex coordinates.
// Both use valid/ready; a beat moves when valid and ready are both high.
// cfg_wr_en with cfg_wr_data sets log2 of the vertex count; reset gives 6.
// Throughput is one beat per cycle unless the receiver stalls. A beat
// passes one front stage that forms the squared distance and phase, a back
// input register, 25 square root stages that also carry the 16 CORDIC
// stages, then quadrant rounding, radius multiply, final add and saturation.
// When the receiver stalls, the back pipeline holds and the front stage and
// s_ready drop once the front register is full; no beat is lost.
// Reset is synchronous and empties both pipelines.
module circle_polygon_vertex_unit #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [3:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  cpv_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cpv_pkg::out_beat_t m_data
);

    localparam int FLOOR_LOG2 = $clog2(MAX_VERTICES + 1) - 1;
    localparam int MAX_LOG2 = (FLOOR_LOG2 > 16) ? 16 :
                              ((FLOOR_LOG2 < 1) ? 1 : FLOOR_LOG2);

    logic job_valid;
    logic job_ready;
    cpv_pkg::job_t job;

    cpv_front #(.MAX_LOG2(MAX_LOG2)) u_front (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_data,
        .in_valid(s_valid), .in_ready(s_ready), .in_beat(s_data),
        .job_valid, .job_ready, .job
    );

    cpv_back u_back (
        .aclk, .aresetn, .job_valid, .job_ready, .job,
        .out_valid(m_valid), .out_ready(m_ready), .out_beat(m_data)
    );

endmodule

// ===== tb/tb.sv =====
module tb;

    localparam int PERIOD = 20;
    localparam int LATENCY = 29;
    localparam int CYCLE_LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [3:0] cfg_wr_data = 4'd0;
    logic s_valid = 1'b0;
    logic s_ready;
    cpv_pkg::in_beat_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    cpv_pkg::out_beat_t m_data;

    circle_polygon_vertex_unit uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    // A pending entry carries a beat, asks the driver only to drain, or asks it
    // to drain and then rewrite the resolution register.
    typedef struct {
        bit is_cfg;
        logic [3:0] cfg_value;
        bit drain;
        cpv_pkg::in_beat_t beat;
    } pending_t;

    pending_t pending_q[$];
    cpv_pkg::out_beat_t expected_vertices[$];
    logic [3:0] resolution_reg;
    int errors = 0;
    longint cycles = 0;
    bit stimulus_done = 1'b0;

    int burst_left = 0;
    int gap_left = 0;
    int settle_left = 0;
    int stall_phase = 0;

    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] tbl [16];
        tbl = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C};
        return tbl[i];
    endfunction

    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint to_q15(input longint v);
        longint r;
        if (v >= 0) r = (v + 16384) >>> 15;
        else r = -(((-v) + 16384) >>> 15);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function automatic longint radius_q8(input longint d2);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] b;
        n = d2 << 16;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic logic signed [15:0] vertex_coord(input longint c, input longint r8,
                                                        input longint trig);
        longint v;
        longint p;
        v = c * (64'sd1 <<< 23) + r8 * trig;
        p = v / (64'sd1 <<< 23);
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return p[15:0];
    endfunction

    function automatic cpv_pkg::out_beat_t predict_vertex(input cpv_pkg::in_beat_t b,
                                                          input logic [3:0] res_log2);
        cpv_pkg::out_beat_t o;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        longint r8;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint c;
        longint s;
        int l;
        logic [31:0] k;
        logic [31:0] phase;
        cx = b.center_x;
        cy = b.center_y;
        dx = cx - longint'(b.rim_x);
        dy = cy - longint'(b.rim_y);
        r8 = radius_q8(dx * dx + dy * dy);
        l = res_log2;
        if (l < 1) l = 1;
        if (l > 10) l = 10;
        k = 32'(b.vertex_index) & ((32'd1 << l) - 1);
        phase = k << (32 - l);
        x = 652032874;
        y = 0;
        z = phase[29:0];
        for (int i = 0; i < 16; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - atan_entry(i);
            end else begin
                x = x + ys; y = y - xs; z = z + atan_entry(i);
            end
        end
        unique case (phase[31:30])
            2'd0: begin c = x; s = y; end
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        o.vertex_x = vertex_coord(cx, r8, to_q15(c));
        o.vertex_y = vertex_coord(cy, r8, to_q15(s));
        return o;
    endfunction

    // Driver: bursts with random gaps, config writes only once drained.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            cfg_wr_en <= 1'b0;
        end else begin
            cfg_wr_en <= 1'b0;
            if (s_valid && !s_ready) begin
                // Hold the beat until it is accepted.
            end else if (settle_left > 0) begin
                s_valid <= 1'b0;
                settle_left <= settle_left - 1;
            end else if (pending_q.size() == 0) begin
                s_valid <= 1'b0;
                stimulus_done <= 1'b1;
            end else if (pending_q[0].is_cfg || pending_q[0].drain) begin
                s_valid <= 1'b0;
                if (!(s_valid && s_ready) && expected_vertices.size() == 0) begin
                    if (pending_q[0].is_cfg) begin
                        cfg_wr_en <= 1'b1;
                        cfg_wr_data <= pending_q[0].cfg_value;
                        resolution_reg <= pending_q[0].cfg_value;
                    end
                    void'(pending_q.pop_front());
                    settle_left <= 2;
                end
            end else if (gap_left > 0) begin
                s_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else begin
                s_valid <= 1'b1;
                s_data <= pending_q[0].beat;
                expected_vertices.push_back(predict_vertex(pending_q[0].beat,
                                                           resolution_reg));
                void'(pending_q.pop_front());
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver stalls follow a repeating phase with random episodes.
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase[8]) m_ready <= 1'b1;
        else if (stall_phase[5]) m_ready <= ($urandom_range(0, 3) != 0);
        else m_ready <= ($urandom_range(0, 2) == 0);
    end

    // Monitor.
    always @(posedge aclk) begin
        cpv_pkg::out_beat_t exp_v;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_vertices.size() == 0) begin
                $error("unexpected result beat x=%0d y=%0d", m_data.vertex_x, m_data.vertex_y);
                errors = errors + 1;
            end else begin
                exp_v = expected_vertices.pop_front();
                if (m_data.vertex_x !== exp_v.vertex_x) begin
                    $error("vertex_x expected %0d actual %0d", exp_v.vertex_x, m_data.vertex_x);
                    errors = errors + 1;
                end
                if (m_data.vertex_y !== exp_v.vertex_y) begin
                    $error("vertex_y expected %0d actual %0d", exp_v.vertex_y, m_data.vertex_y);
                    errors = errors + 1;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_beat(input logic signed [15:0] cx, input logic signed [15:0] cy,
                            input logic signed [15:0] rx, input logic signed [15:0] ry,
                            input logic [9:0] idx);
        pending_t p;
        p.is_cfg = 1'b0;
        p.drain = 1'b0;
        p.cfg_value = '0;
        p.beat.center_x = cx;
        p.beat.center_y = cy;
        p.beat.rim_x = rx;
        p.beat.rim_y = ry;
        p.beat.vertex_index = idx;
        pending_q.push_back(p);
    endtask

    task automatic add_resolution(input logic [3:0] v);
        pending_t p;
        p.is_cfg = 1'b1;
        p.drain = 1'b0;
        p.cfg_value = v;
        p.beat = '0;
        pending_q.push_back(p);
    endtask

    task automatic add_drain();
        pending_t p;
        p.is_cfg = 1'b0;
        p.drain = 1'b1;
        p.cfg_value = '0;
        p.beat = '0;
        pending_q.push_back(p);
    endtask

    task automatic add_random(input int n);
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        for (int i = 0; i < n; i++) begin
            cx = 16'($urandom);
            cy = 16'($urandom);
            case ($urandom_range(0, 3))
                0: add_beat(cx, cy, 16'($urandom), 16'($urandom), 10'($urandom));
                1: add_beat(cx, cy, cx + 16'($signed(6'($urandom))),
                            cy + 16'($signed(6'($urandom))), 10'($urandom));
                2: add_beat(16'($signed(11'($urandom))), 16'($signed(11'($urandom))),
                            16'($signed(11'($urandom))), 16'($signed(11'($urandom))),
                            10'($urandom));
                default: add_beat(cx, cy, cx, cy, 10'($urandom));
            endcase
        end
    endtask

    initial begin
        int wait_cycles;
        resolution_reg = 4'd6;
        add_beat(16'sd0, 16'sd0, 16'sd100, 16'sd0, 10'd0);
        add_beat(16'sd0, 16'sd0, 16'sd100, 16'sd0, 10'd16);
        add_beat(16'sd0, 16'sd0, 16'sd100, 16'sd0, 10'd32);
        add_beat(16'sd0, 16'sd0, 16'sd100, 16'sd0, 10'd48);
        add_beat(16'sd0, 16'sd0, 16'sd0, 16'sd77, 10'd8);
        add_beat(16'sd1234, -16'sd567, 16'sd1234, -16'sd567, 10'd5);
        add_beat(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 10'd0);
        add_beat(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 10'd32);
        add_beat(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 10'd1023);
        add_beat(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 10'd700);
        add_beat(-16'sd1, -16'sd1, 16'sd0, 16'sd0, 10'h2AA);
        add_beat(16'sd0, 16'sd0, 16'sd3, 16'sd4, 10'h155);
        add_resolution(4'd0);
        add_beat(16'sd10, 16'sd20, 16'sd50, 16'sd20, 10'd1);
        add_beat(16'sd10, 16'sd20, 16'sd50, 16'sd20, 10'd1022);
        add_resolution(4'd15);
        add_beat(16'sd0, 16'sd0, 16'sd1000, 16'sd0, 10'd1023);
        add_beat(16'sd0, 16'sd0, 16'sd1000, 16'sd0, 10'd256);
        add_resolution(4'd10);
        add_beat(16'sd0, 16'sd0, 16'sd1000, 16'sd0, 10'd128);
        add_resolution(4'd1);
        add_beat(16'sd5, 16'sd5, 16'sd9, 16'sd5, 10'd3);
        add_random(150);
        add_resolution(4'd3);
        add_random(150);
        add_drain();
        add_random(100);
        add_resolution(4'd10);
        add_random(150);
        add_resolution(4'd7);
        add_random(120);
        add_resolution(4'd12);
        add_random(110);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stimulus_done && expected_vertices.size() == 0);
        wait_cycles = 0;
        while (wait_cycles < 2 * LATENCY) begin
            @(posedge aclk);
            wait_cycles++;
        end
        if (errors == 0 && expected_vertices.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/cpv_pkg.sv
rtl/cpv_front.sv
rtl/cpv_back.sv
rtl/circle_polygon_vertex_unit.sv
tb/tb.sv
